// ===== src/ffea_pkg.sv =====
// Shared types and constants for the first-fit extent allocator.
// No dependencies; every other file of the block imports this package.
package ffea_pkg;

	localparam int FIELD_W     = 32;
	localparam int STATUS_W    = 2;
	localparam int TOTAL_W     = 7;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_BLOCK = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BUF_SIZE  = 1'b1;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_BADFREE = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_GATHER = 5'b00100,
		S_DECIDE = 5'b01000,
		S_APPLY  = 5'b10000
	} state_t;

	// Update command broadcast to every cell of the extent row.
	typedef struct packed {
		logic init;
		logic remove;
		logic insert;
		logic wr_sel;
		logic wr_lo;
	} cell_ctl_t;

endpackage

// ===== src/ffea_if.sv =====
// Valid/ready channels of the extent allocator: request and result items.
// Depends on ffea_pkg for the field widths.
interface ffea_req_if import ffea_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               kind;
	logic [FIELD_W-1:0] block_offset;
	logic [FIELD_W-1:0] block_size;

	modport source (output valid, kind, block_offset, block_size, input ready);
	modport sink (input valid, kind, block_offset, block_size, output ready);
endinterface

interface ffea_rsp_if import ffea_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FIELD_W-1:0]  result_offset;
	logic [FIELD_W-1:0]  result_length;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0]  extent_total;

	modport source (output valid, result_offset, result_length, status, extent_total,
		input ready);
	modport sink (input valid, result_offset, result_length, status, extent_total,
		output ready);
endinterface

// ===== src/first_fit_extent_allocator_unit.sv =====
// First-fit extent allocator: top level with control sequencer and the extent row.
// Depends on ffea_pkg, ffea_if (channel interfaces) and ffea_cell.
//
// The block keeps up to MAX_EXTENTS free extents, sorted by offset, in a row of
// cells; one cell holds one extent and shifts it to a neighbor on insert or
// remove. Each item goes through these steps up to a registered result: accept,
// a scan in which every cell compares its extent against the request at once
// (the first-fit marker ripples down the row), a gather of the chosen and the
// lower neighbor extents, a check that computes the new values, and an update
// in which the whole row updates and shifts in parallel. A new item is accepted
// while the previous result is still waiting to be taken; the update step holds
// only if that result has still not been taken. No new item is accepted until
// the row update of the last one. A write of buffer_size rebuilds the table at
// once as one extent covering the buffer, or an empty table for zero.
module first_fit_extent_allocator_unit import ffea_pkg::*; #(
	parameter int MAX_EXTENTS  = 64,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ffea_req_if.sink               req,
	ffea_rsp_if.source             rsp,
	input  logic                   cfg_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [FIELD_W-1:0]     cfg_wdata
);

	localparam int N  = MAX_EXTENTS;
	localparam int W  = OFFSET_WIDTH;
	localparam int CW = $clog2(N + 1);
	localparam logic [W-1:0]  RESET_BUF   = W'(65536);
	localparam logic [CW-1:0] RESET_COUNT = (RESET_BUF != '0) ? CW'(1) : CW'(0);

	state_t         state_q;
	logic [W-1:0]   min_size_q;
	logic [W-1:0]   buf_size_q;
	logic [CW-1:0]  count_q;

	// Request registers.
	logic           is_alloc_q;
	logic [W-1:0]   off_q;
	logic [W-1:0]   size_q;
	logic [W:0]     end_q;

	// Gathered extents.
	logic           any_sel_q;
	logic           any_lo_q;
	logic [W-1:0]   sel_start_q;
	logic [W-1:0]   sel_len_q;
	logic [W-1:0]   lo_start_q;
	logic [W-1:0]   lo_len_q;

	// Decided update.
	cell_ctl_t      ctl_q;
	logic [W-1:0]   wr_start_q;
	logic [W-1:0]   wr_len_q;
	status_t        status_q;
	logic [W-1:0]   roff_q;
	logic [W-1:0]   rlen_q;

	// Result register.
	logic                rsp_valid_q;
	logic [FIELD_W-1:0]  rsp_off_q;
	logic [FIELD_W-1:0]  rsp_len_q;
	status_t             rsp_status_q;
	logic [TOTAL_W-1:0]  rsp_total_q;

	logic           accept;
	logic           go;
	logic           cfg_buf_wr;
	logic [W-1:0]   in_off;
	logic [W-1:0]   in_size;
	cell_ctl_t      ctl;
	logic [W-1:0]   wr_start;
	logic [W-1:0]   wr_len;
	logic [CW-1:0]  count_next;

	logic [N-1:0]   ge_c;
	logic [N-1:0]   ge_q;
	logic [N-1:0]   sel_q;
	logic [N-1:0]   lo;
	logic [W-1:0]   start_q [N];
	logic [W-1:0]   len_q   [N];

	logic           any_sel;
	logic           any_lo;
	logic [W-1:0]   sel_start;
	logic [W-1:0]   sel_len;
	logic [W-1:0]   lo_start;
	logic [W-1:0]   lo_len;

	logic [W:0]     lo_end;
	logic           bad_free;
	logic           touch_lo;
	logic           touch_hi;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign go         = (state_q == S_APPLY) && (!rsp_valid_q || rsp.ready);
	assign cfg_buf_wr = cfg_en && (cfg_index == CFG_BUF_SIZE);
	assign in_off     = W'(req.block_offset);
	assign in_size    = W'(req.block_size);

	always_comb begin
		ctl      = '0;
		wr_start = wr_start_q;
		wr_len   = wr_len_q;
		if (cfg_buf_wr) begin
			ctl.init = 1'b1;
			wr_start = '0;
			wr_len   = W'(cfg_wdata);
		end else if (go) begin
			ctl = ctl_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:   if (accept) state_q <= S_SCAN;
				S_SCAN:   state_q <= S_GATHER;
				S_GATHER: state_q <= S_DECIDE;
				S_DECIDE: state_q <= S_APPLY;
				S_APPLY:  if (go) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Configuration registers and extent count.
	always_comb begin
		count_next = count_q;
		if (ctl.remove) begin
			count_next = count_q - CW'(1);
		end else if (ctl.insert) begin
			count_next = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q <= W'(1);
			buf_size_q <= RESET_BUF;
			count_q    <= RESET_COUNT;
		end else begin
			if (cfg_en && (cfg_index == CFG_MIN_BLOCK)) begin
				min_size_q <= W'(cfg_wdata);
			end
			if (cfg_buf_wr) begin
				buf_size_q <= W'(cfg_wdata);
				count_q    <= (W'(cfg_wdata) != '0) ? CW'(1) : CW'(0);
			end else begin
				count_q <= count_next;
			end
		end
	end

	// Request capture; allocation sizes are raised to the minimum here.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_alloc_q <= (req.kind == KIND_ALLOC);
			off_q      <= in_off;
			size_q     <= ((req.kind == KIND_ALLOC) && (min_size_q > in_size)) ?
				min_size_q : in_size;
			end_q      <= {1'b0, in_off} + {1'b0, in_size};
		end
	end

	// The extent row.
	for (genvar i = 0; i < N; i++) begin : g_cell
		ffea_cell #(
			.W         (W),
			.CW        (CW),
			.INDEX     (i),
			.RESET_LEN (RESET_BUF)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.count      (count_q),
			.scan_en    (state_q == S_SCAN),
			.is_alloc   (is_alloc_q),
			.req_off    (off_q),
			.req_size   (size_q),
			.prev_ge_c  ((i == 0) ? 1'b0 : ge_c[(i == 0) ? 0 : i - 1]),
			.ge_c       (ge_c[i]),
			.prev_ge_q  ((i == 0) ? 1'b0 : ge_q[(i == 0) ? 0 : i - 1]),
			.next_ge_q  ((i == N - 1) ? 1'b1 : ge_q[(i == N - 1) ? i : i + 1]),
			.ge_q       (ge_q[i]),
			.sel_q      (sel_q[i]),
			.lo         (lo[i]),
			.prev_start ((i == 0) ? '0 : start_q[(i == 0) ? 0 : i - 1]),
			.prev_len   ((i == 0) ? '0 : len_q[(i == 0) ? 0 : i - 1]),
			.next_start ((i == N - 1) ? '0 : start_q[(i == N - 1) ? i : i + 1]),
			.next_len   ((i == N - 1) ? '0 : len_q[(i == N - 1) ? i : i + 1]),
			.ctl        (ctl),
			.wr_start   (wr_start),
			.wr_len     (wr_len),
			.start_q    (start_q[i]),
			.len_q      (len_q[i])
		);
	end

	// Pick out the marked extent (first fit, or the one above a freed block)
	// and the extent just below a freed block; both marks are at most one-hot.
	always_comb begin
		sel_start = '0;
		sel_len   = '0;
		lo_start  = '0;
		lo_len    = '0;
		for (int i = 0; i < N; i++) begin
			sel_start = sel_start | (start_q[i] & {W{sel_q[i]}});
			sel_len   = sel_len   | (len_q[i]   & {W{sel_q[i]}});
			lo_start  = lo_start  | (start_q[i] & {W{lo[i]}});
			lo_len    = lo_len    | (len_q[i]   & {W{lo[i]}});
		end
	end
	assign any_sel = |sel_q;
	assign any_lo  = |lo;

	always_ff @(posedge clk) begin
		if (state_q == S_GATHER) begin
			any_sel_q   <= any_sel;
			any_lo_q    <= any_lo;
			sel_start_q <= sel_start;
			sel_len_q   <= sel_len;
			lo_start_q  <= lo_start;
			lo_len_q    <= lo_len;
		end
	end

	// Checks and new extent values.
	assign lo_end   = {1'b0, lo_start_q} + {1'b0, lo_len_q};
	assign bad_free = (size_q == '0) || end_q[W] || (end_q > {1'b0, buf_size_q}) ||
		(any_lo_q && (lo_end > {1'b0, off_q})) ||
		(any_sel_q && ({1'b0, sel_start_q} < end_q));
	assign touch_lo = any_lo_q && (lo_end == {1'b0, off_q});
	assign touch_hi = any_sel_q && ({1'b0, sel_start_q} == end_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (state_q == S_DECIDE) begin
			ctl_q <= '0;
			if (is_alloc_q) begin
				if (any_sel_q) begin
					ctl_q.remove <= (sel_len_q == size_q);
					ctl_q.wr_sel <= (sel_len_q != size_q);
				end
			end else if (!bad_free) begin
				if (touch_lo) begin
					ctl_q.wr_lo  <= 1'b1;
					ctl_q.remove <= touch_hi;
				end else if (touch_hi) begin
					ctl_q.wr_sel <= 1'b1;
				end else if (count_q != CW'(N)) begin
					ctl_q.insert <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DECIDE) begin
			roff_q     <= '0;
			rlen_q     <= '0;
			wr_start_q <= off_q;
			wr_len_q   <= size_q;
			if (is_alloc_q) begin
				if (any_sel_q) begin
					status_q   <= STAT_OK;
					roff_q     <= sel_start_q;
					rlen_q     <= size_q;
					wr_start_q <= sel_start_q + size_q;
					wr_len_q   <= sel_len_q - size_q;
				end else begin
					status_q <= STAT_NOFIT;
				end
			end else if (bad_free) begin
				status_q <= STAT_BADFREE;
			end else if (touch_lo) begin
				status_q   <= STAT_OK;
				wr_start_q <= lo_start_q;
				wr_len_q   <= lo_len_q + size_q + (touch_hi ? sel_len_q : '0);
			end else if (touch_hi) begin
				status_q <= STAT_OK;
				wr_len_q <= sel_len_q + size_q;
			end else if (count_q != CW'(N)) begin
				status_q <= STAT_OK;
			end else begin
				status_q <= STAT_FULL;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (go) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_off_q    <= FIELD_W'(roff_q);
			rsp_len_q    <= FIELD_W'(rlen_q);
			rsp_status_q <= status_q;
			rsp_total_q  <= TOTAL_W'(count_next);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.result_offset = rsp_off_q;
	assign rsp.result_length = rsp_len_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.extent_total  = rsp_total_q;

	// The table never grows past its capacity or shrinks below empty.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(N))
		else $error("extent count above capacity");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctl_q.insert) |-> (count_q != CW'(N)))
		else $error("insert into a full table");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctl_q.remove) |-> (count_q != '0))
		else $error("remove from an empty table");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_q) && $onehot0(lo))
		else $error("more than one extent selected");

	a_result_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_APPLY))
		else $error("result produced outside the update step");

endmodule

// ===== src/ffea_cell.sv =====
// One slot of the extent row: holds one free extent and shifts with its neighbors.
// Depends on ffea_pkg for the command struct.
module ffea_cell import ffea_pkg::*; #(
	parameter int W       = 32,
	parameter int CW      = 7,
	parameter int INDEX   = 0,
	parameter logic [W-1:0] RESET_LEN = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] count,
	input  logic          scan_en,
	input  logic          is_alloc,
	input  logic [W-1:0]  req_off,
	input  logic [W-1:0]  req_size,
	input  logic          prev_ge_c,
	output logic          ge_c,
	input  logic          prev_ge_q,
	input  logic          next_ge_q,
	output logic          ge_q,
	output logic          sel_q,
	output logic          lo,
	input  logic [W-1:0]  prev_start,
	input  logic [W-1:0]  prev_len,
	input  logic [W-1:0]  next_start,
	input  logic [W-1:0]  next_len,
	input  cell_ctl_t     ctl,
	input  logic [W-1:0]  wr_start,
	input  logic [W-1:0]  wr_len,
	output logic [W-1:0]  start_q,
	output logic [W-1:0]  len_q
);

	logic valid;
	logic fit;
	logic lt;
	logic first;

	assign valid = CW'(INDEX) < count;
	assign fit   = valid && (len_q >= req_size);
	assign lt    = valid && (start_q < req_off);
	// Allocation: the marker ripples from the first fitting extent onward.
	// Free: the table is sorted, so "not below the offset" is already a suffix.
	assign ge_c  = is_alloc ? (prev_ge_c | fit) : !lt;
	assign lo    = !ge_q && next_ge_q;
	assign first = ge_q && !prev_ge_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ge_q  <= 1'b0;
			sel_q <= 1'b0;
		end else if (scan_en) begin
			ge_q  <= ge_c;
			sel_q <= ge_c && !prev_ge_c && valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			len_q   <= (INDEX == 0) ? RESET_LEN : '0;
		end else if (ctl.init) begin
			start_q <= '0;
			len_q   <= wr_len;
		end else if (ctl.remove && ge_q) begin
			start_q <= next_start;
			len_q   <= next_len;
		end else if (ctl.insert && ge_q) begin
			start_q <= first ? wr_start : prev_start;
			len_q   <= first ? wr_len : prev_len;
		end else if ((ctl.wr_sel && sel_q) || (ctl.wr_lo && lo)) begin
			start_q <= wr_start;
			len_q   <= wr_len;
		end
	end

endmodule
